@@ src/ttint_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttint_pkg: shared definitions of the temperature table interpolator
// Sizes of the grid and coefficient stores, field widths, operation codes
// and configuration register indexes.
// ----------------------------------------------------------------------------
package ttint_pkg;

  // Store sizes
  localparam int MAX_TEMPS       = 64;
  localparam int MAX_TRANSITIONS = 32;

  localparam int TEMP_AW    = $clog2(MAX_TEMPS);
  localparam int TRANS_AW   = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
  localparam int RATE_DEPTH = MAX_TEMPS * MAX_TRANSITIONS;
  localparam int RATE_AW    = $clog2(RATE_DEPTH);

  // Field widths
  localparam int OP_W        = 2;
  localparam int GRID_IDX_W  = 6;
  localparam int TRANS_IDX_W = 5;
  localparam int TEMP_W      = 24;
  localparam int COEF_W      = 32;
  localparam int NUM_TEMPS_W = 7;
  localparam int NUM_TRANS_W = 6;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;

  // Datapath widths: product of |dt| and |dy|, rounded dividend, final sum
  localparam int PROD_W     = TEMP_W + COEF_W;
  localparam int DIVD_W     = PROD_W;
  localparam int SUM_W      = DIVD_W + 1;
  localparam int DIV_STEPS  = DIVD_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_GRID = 2'd0,
    OP_WRITE_COEF = 2'd1,
    OP_QUERY      = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_TEMPS       = 1'b0,
    REG_NUM_TRANSITIONS = 1'b1
  } reg_idx_e;

endpackage

@@ src/temperature_table_interpolator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temperature_table_interpolator: piecewise linear coefficient lookup
// Holds a temperature grid and a coefficient table, answers a query with one
// interpolated, clipped coefficient per transition.
// ----------------------------------------------------------------------------
// A write transaction (grid point or coefficient) is absorbed and produces
// nothing; writes beyond the store size are dropped, and neither store is
// cleared at reset, so a query must only touch entries that were written. A
// query walks the grid one entry per cycle from point 1 until it finds the
// first point above the query temperature (or reaches the last point in
// use). Each transition then goes through two coefficient reads, forming
// |dy|, the 24x32 multiply, adding the rounding offset, a one-bit-per-cycle
// restoring divider for the 56 quotient bits and a clip that hands the result
// to the output register once it is free. When both bracketing temperatures
// are equal the multiply, rounding and divider are skipped. The input side is
// ready only between queries; the output register lets the sequencer work on
// the next transition while a result waits to be taken. num_temps is used
// clamped to [2, 64] and num_transitions to [1, 32]; both are latched when a
// query is accepted.
module temperature_table_interpolator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [ttint_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ttint_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ttint_pkg::OP_W-1:0]          operation_i,
  input  logic [ttint_pkg::GRID_IDX_W-1:0]    grid_index_i,
  input  logic [ttint_pkg::TRANS_IDX_W-1:0]   transition_index_i,
  input  logic [ttint_pkg::TEMP_W-1:0]        temperature_i,
  input  logic [ttint_pkg::COEF_W-1:0]        coefficient_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [ttint_pkg::TRANS_IDX_W-1:0]   out_transition_o,
  output logic [ttint_pkg::COEF_W-1:0]        rate_value_o,
  output logic                                last_o
);

  localparam int TEMP_AW  = ttint_pkg::TEMP_AW;
  localparam int TRANS_AW = ttint_pkg::TRANS_AW;
  localparam int RATE_AW  = ttint_pkg::RATE_AW;
  localparam int TEMP_W   = ttint_pkg::TEMP_W;
  localparam int COEF_W   = ttint_pkg::COEF_W;
  localparam int DIVD_W   = ttint_pkg::DIVD_W;
  localparam int SUM_W    = ttint_pkg::SUM_W;
  localparam int CNT_W    = ttint_pkg::DIV_CNT_W;

  // Sequencer states, one-hot
  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_LOAD0  = 11'b000_0000_0010,  // grid point 0 arrives
    S_SEARCH = 11'b000_0000_0100,  // compare grid[k] against the query
    S_DIFF   = 11'b000_0000_1000,  // form |dt| and |den|
    S_RD0    = 11'b000_0001_0000,  // read lower coefficient
    S_RD1    = 11'b000_0010_0000,  // read upper coefficient
    S_DY     = 11'b000_0100_0000,  // form |dy|
    S_MUL    = 11'b000_1000_0000,  // |dt| * |dy|
    S_DINIT  = 11'b001_0000_0000,  // add rounding offset
    S_DIV    = 11'b010_0000_0000,  // one quotient bit per cycle
    S_OUT    = 11'b100_0000_0000   // clip and load output register
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [ttint_pkg::NUM_TEMPS_W-1:0] num_temps_q;
  logic [ttint_pkg::NUM_TRANS_W-1:0] num_trans_q;

  // Memories
  logic [TEMP_W-1:0] grid_mem [ttint_pkg::MAX_TEMPS];
  logic [COEF_W-1:0] rate_mem [ttint_pkg::RATE_DEPTH];
  logic [TEMP_W-1:0] grid_rdata_q;
  logic [COEF_W-1:0] rate_rdata_q;
  logic [TEMP_AW-1:0] grid_raddr;
  logic [RATE_AW-1:0] rate_raddr;
  logic [TEMP_AW-1:0] rate_row;

  // Query context
  logic [TEMP_W-1:0]   t_q;
  logic [TEMP_AW-1:0]  n_last_q;
  logic [TRANS_AW-1:0] m_last_q;
  logic [TEMP_AW-1:0]  k_q;
  logic [TEMP_AW-1:0]  lo_q;
  logic [TEMP_AW-1:0]  hi_q;
  logic [TEMP_W-1:0]   prev_q;
  logic [TEMP_W-1:0]   x1_q;
  logic [TRANS_AW-1:0] j_q;

  // Arithmetic
  logic                dt_neg_q, den_neg_q, dy_neg_q, den_zero_q;
  logic [TEMP_W-1:0]   dt_mag_q, den_mag_q;
  logic [COEF_W-1:0]   y0_q, dy_mag_q;
  logic [DIVD_W-1:0]   prod_q;
  logic [DIVD_W-1:0]   divd_q;      // dividend, shifts into quotient
  logic [TEMP_W-1:0]   rem_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [TEMP_W:0]     trial;
  logic                trial_ge;
  logic [SUM_W-1:0]    pos_sum;
  logic                neg_res;
  logic [COEF_W-1:0]   result;
  logic                hit;

  // Output register
  logic                       out_valid_q;
  logic [TRANS_AW-1:0]        out_trans_q;
  logic [COEF_W-1:0]          out_rate_q;
  logic                       out_last_q;
  logic                       out_load;

  logic        in_accept;
  logic        grid_we, rate_we;
  logic [31:0] n_used, m_used;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  assign grid_we = in_accept && (operation_i == ttint_pkg::OP_WRITE_GRID) &&
                   (32'(grid_index_i) < 32'(ttint_pkg::MAX_TEMPS));
  assign rate_we = in_accept && (operation_i == ttint_pkg::OP_WRITE_COEF) &&
                   (32'(grid_index_i) < 32'(ttint_pkg::MAX_TEMPS)) &&
                   (32'(transition_index_i) < 32'(ttint_pkg::MAX_TRANSITIONS));

  // Clamp register values to the usable range
  always_comb begin
    n_used = 32'(num_temps_q);
    if (n_used < 32'd2) n_used = 32'd2;
    if (n_used > 32'(ttint_pkg::MAX_TEMPS)) n_used = 32'(ttint_pkg::MAX_TEMPS);
    m_used = 32'(num_trans_q);
    if (m_used < 32'd1) m_used = 32'd1;
    if (m_used > 32'(ttint_pkg::MAX_TRANSITIONS)) begin
      m_used = 32'(ttint_pkg::MAX_TRANSITIONS);
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_temps_q <= ttint_pkg::NUM_TEMPS_W'(2);
      num_trans_q <= ttint_pkg::NUM_TRANS_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ttint_pkg::REG_NUM_TEMPS:       num_temps_q <= cfg_data_i;
        ttint_pkg::REG_NUM_TRANSITIONS: num_trans_q <= ttint_pkg::NUM_TRANS_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Grid memory: write on transaction, read address from the search walk
  always_comb begin
    case (state_q)
      S_LOAD0:  grid_raddr = TEMP_AW'(1);
      S_SEARCH: grid_raddr = k_q + TEMP_AW'(1);
      default:  grid_raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (grid_we) begin
      grid_mem[TEMP_AW'(grid_index_i)] <= temperature_i;
    end
    grid_rdata_q <= grid_mem[grid_raddr];
  end

  // Coefficient memory: row-major, one row per grid point
  assign rate_row   = (state_q == S_RD1) ? hi_q : lo_q;
  assign rate_raddr = RATE_AW'(rate_row) * RATE_AW'(ttint_pkg::MAX_TRANSITIONS) +
                      RATE_AW'(j_q);

  always_ff @(posedge clk_i) begin
    if (rate_we) begin
      rate_mem[RATE_AW'(grid_index_i) * RATE_AW'(ttint_pkg::MAX_TRANSITIONS) +
               RATE_AW'(transition_index_i)] <= coefficient_i;
    end
    rate_rdata_q <= rate_mem[rate_raddr];
  end

  // Search: the upper bracket is the first point above the query, or the last point
  assign hit = (grid_rdata_q > t_q) || (k_q == n_last_q);

  // Divider step
  assign trial    = {rem_q, divd_q[DIVD_W-1]};
  assign trial_ge = (trial >= {1'b0, den_mag_q});

  // Final add with clipping at zero and saturation at all ones
  assign neg_res = dt_neg_q ^ dy_neg_q ^ den_neg_q;
  assign pos_sum = SUM_W'(divd_q) + SUM_W'(y0_q);

  always_comb begin
    if (neg_res) begin
      if (SUM_W'(divd_q) > SUM_W'(y0_q)) result = '0;
      else                                result = y0_q - divd_q[COEF_W-1:0];
    end else begin
      if (|pos_sum[SUM_W-1:COEF_W]) result = '1;
      else                          result = pos_sum[COEF_W-1:0];
    end
  end

  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept && (operation_i == ttint_pkg::OP_QUERY)) state_d = S_LOAD0;
      end
      S_LOAD0:  state_d = S_SEARCH;
      S_SEARCH: if (hit) state_d = S_DIFF;
      S_DIFF:   state_d = S_RD0;
      S_RD0:    state_d = S_RD1;
      S_RD1:    state_d = S_DY;
      S_DY:     state_d = den_zero_q ? S_OUT : S_MUL;
      S_MUL:    state_d = S_DINIT;
      S_DINIT:  state_d = S_DIV;
      S_DIV:    if (cnt_q == '0) state_d = S_OUT;
      S_OUT: begin
        if (out_load) state_d = (j_q == m_last_q) ? S_IDLE : S_RD0;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        t_q      <= temperature_i;
        n_last_q <= TEMP_AW'(n_used - 32'd1);
        m_last_q <= TRANS_AW'(m_used - 32'd1);
        j_q      <= '0;
      end
      S_LOAD0: begin
        prev_q <= grid_rdata_q;
        k_q    <= TEMP_AW'(1);
      end
      S_SEARCH: begin
        if (hit) begin
          hi_q <= k_q;
          lo_q <= k_q - TEMP_AW'(1);
          x1_q <= grid_rdata_q;
        end else begin
          prev_q <= grid_rdata_q;
          k_q    <= k_q + TEMP_AW'(1);
        end
      end
      S_DIFF: begin
        dt_neg_q   <= (t_q < prev_q);
        dt_mag_q   <= (t_q < prev_q) ? prev_q - t_q : t_q - prev_q;
        den_neg_q  <= (x1_q < prev_q);
        den_mag_q  <= (x1_q < prev_q) ? prev_q - x1_q : x1_q - prev_q;
        den_zero_q <= (x1_q == prev_q);
      end
      S_RD1: y0_q <= rate_rdata_q;
      S_DY: begin
        dy_neg_q <= (rate_rdata_q < y0_q);
        dy_mag_q <= (rate_rdata_q < y0_q) ? y0_q - rate_rdata_q : rate_rdata_q - y0_q;
        divd_q   <= '0;  // quotient stays zero when the bracket is flat
      end
      S_MUL: prod_q <= DIVD_W'(dt_mag_q) * DIVD_W'(dy_mag_q);
      S_DINIT: begin
        divd_q <= prod_q + DIVD_W'(den_mag_q >> 1);
        rem_q  <= '0;
        cnt_q  <= CNT_W'(ttint_pkg::DIV_STEPS - 1);
      end
      S_DIV: begin
        rem_q  <= trial_ge ? TEMP_W'(trial - {1'b0, den_mag_q}) : trial[TEMP_W-1:0];
        divd_q <= {divd_q[DIVD_W-2:0], trial_ge};
        cnt_q  <= cnt_q - CNT_W'(1);
      end
      S_OUT: begin
        if (out_load) j_q <= j_q + TRANS_AW'(1);
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_trans_q <= j_q;
      out_rate_q  <= result;
      out_last_q  <= (j_q == m_last_q);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_transition_o = ttint_pkg::TRANS_IDX_W'(out_trans_q);
  assign rate_value_o     = out_rate_q;
  assign last_o           = out_last_q;

  // Assertions
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q != '0) |=>
      (state_q == S_DIV && cnt_q == $past(cnt_q) - CNT_W'(1)))
    else $error("divider step count broken");

  a_bracket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIFF) |->
      (hi_q != '0 && lo_q == hi_q - TEMP_AW'(1) && hi_q <= n_last_q))
    else $error("bracket pair inconsistent");

  a_last_ends_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && j_q == m_last_q) |=> (state_q == S_IDLE && out_valid_q && out_last_q))
    else $error("final transition did not end the query");

  a_trans_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD0 || state_q == S_OUT) |-> (j_q <= m_last_q))
    else $error("transition counter beyond the count in use");

endmodule
